/* rtl/llf_pkg.sv */
package llf_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    // guard bits carried on every lattice node above the sample width
    localparam int GUARD_BITS = 8;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LATTICE_LO = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LATTICE_HI = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LADDER_LO  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LADDER_MID = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LADDER_TOP = 3'd4;

endpackage

/* rtl/lattice_ladder_iir_filter.sv */
// Fourth-order lattice-ladder IIR filter, fixed point.
//
//  channel   dir  signals                               fields (low bit up)
//  -------   ---  ------------------------------------  ----------------------
//  s_axis    in   s_axis_tvalid/tready/tdata            sample_in
//  m_axis    out  m_axis_tvalid/tready/tdata            sample_out
//  cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data       gain registers 0..4
//
//  Per item, accept to next accept: 13 multiplies issued one a cycle into the
//  shared multiplier, then the last writeback, then the load of the output
//  register, then an idle step with s_axis_tready high.
//  Synchronous active-low reset clears gains, backward delays and handshake state.
//  A result held on m_axis stalls only the final load; the next item is taken
//  in the cycle after the previous one has been loaded.
module lattice_ladder_iir_filter #(
    parameter int SAMPLE_BITS = llf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = llf_pkg::COEF_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample_in
    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // sample_out
    // gain registers
    input  logic                                  i_cfg_we,
    input  logic [llf_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [2*COEF_BITS-1:0]                i_cfg_data
);

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int NB = SAMPLE_BITS + llf_pkg::GUARD_BITS;  // node width
    localparam int RW = NB + 3;                             // rounded product
    localparam int SW = NB + 4;                             // node sum
    localparam int AW = NB + 6;                             // ladder accumulator
    localparam int CB = COEF_BITS;

    localparam logic signed [NB-1:0] NODE_MAX = {1'b0, {(NB - 1){1'b1}}};
    localparam logic signed [NB-1:0] NODE_MIN = {1'b1, {(NB - 1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // multiply issue slots, in issue order; P_LAST issues nothing
    typedef enum logic [3:0] {
        P_K3D3, P_K2D2, P_K1D1, P_K0D0,
        P_K1F1, P_K2F2, P_K3F3, P_K0G0,
        P_A0G4, P_A1G3, P_A2G2, P_A3G1, P_A4G0,
        P_LAST
    } t_step;

    // gain registers
    logic [2*CB-1:0]        r_lat_lo, r_lat_hi, r_lad_lo, r_lad_mid;
    logic signed [CB-1:0]   r_lad_top;

    // control
    t_state                 r_state;
    t_step                  r_step, r_wb;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;

    // datapath
    logic signed [NB-1:0]   r_x, r_f3, r_f2, r_f1, r_g0, r_g1, r_g2, r_g3, r_g4;
    logic signed [NB-1:0]   r_dly [0:3];
    logic signed [AW-1:0]   r_acc;

    logic signed [CB-1:0]   w_coef;
    logic signed [NB-1:0]   w_opnd;
    logic signed [RW-1:0]   w_rnd;
    logic signed [NB-1:0]   w_addend;
    logic                   w_sub;
    logic signed [SW-1:0]   w_sum;
    logic signed [NB-1:0]   w_node;
    logic signed [AW-1:0]   w_acc_sum;
    logic [SAMPLE_BITS-1:0] w_y;
    logic                   w_accept, w_commit;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DW'(r_out_data);

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_lo  <= '0;
            r_lat_hi  <= '0;
            r_lad_lo  <= '0;
            r_lad_mid <= '0;
            r_lad_top <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                llf_pkg::CFG_LATTICE_LO: r_lat_lo  <= i_cfg_data;
                llf_pkg::CFG_LATTICE_HI: r_lat_hi  <= i_cfg_data;
                llf_pkg::CFG_LADDER_LO:  r_lad_lo  <= i_cfg_data;
                llf_pkg::CFG_LADDER_MID: r_lad_mid <= i_cfg_data;
                llf_pkg::CFG_LADDER_TOP: r_lad_top <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // ---- issue: gain and node into the multiplier ----
    always_comb begin
        w_coef = '0;
        w_opnd = '0;
        case (r_step)
            P_K3D3: begin w_coef = r_lat_hi[2*CB-1:CB]; w_opnd = r_dly[3]; end
            P_K2D2: begin w_coef = r_lat_hi[CB-1:0];    w_opnd = r_dly[2]; end
            P_K1D1: begin w_coef = r_lat_lo[2*CB-1:CB]; w_opnd = r_dly[1]; end
            P_K0D0: begin w_coef = r_lat_lo[CB-1:0];    w_opnd = r_dly[0]; end
            P_K1F1: begin w_coef = r_lat_lo[2*CB-1:CB]; w_opnd = r_f1;     end
            P_K2F2: begin w_coef = r_lat_hi[CB-1:0];    w_opnd = r_f2;     end
            P_K3F3: begin w_coef = r_lat_hi[2*CB-1:CB]; w_opnd = r_f3;     end
            P_K0G0: begin w_coef = r_lat_lo[CB-1:0];    w_opnd = r_g0;     end
            P_A0G4: begin w_coef = r_lad_lo[CB-1:0];    w_opnd = r_g4;     end
            P_A1G3: begin w_coef = r_lad_lo[2*CB-1:CB]; w_opnd = r_g3;     end
            P_A2G2: begin w_coef = r_lad_mid[CB-1:0];   w_opnd = r_g2;     end
            P_A3G1: begin w_coef = r_lad_mid[2*CB-1:CB]; w_opnd = r_g1;    end
            P_A4G0: begin w_coef = r_lad_top;           w_opnd = r_g0;     end
            default: ;
        endcase
    end

    llf_mul #(
        .COEF_BITS (COEF_BITS),
        .NODE_BITS (NB)
    ) u_mul (
        .i_clk  (i_clk),
        .i_coef (w_coef),
        .i_opnd (w_opnd),
        .o_rnd  (w_rnd)
    );

    // ---- writeback: lattice node add/subtract with saturation ----
    always_comb begin
        w_addend = r_x;
        w_sub    = 1'b1;
        case (r_wb)
            P_K3D3: begin w_addend = r_x;    w_sub = 1'b1; end
            P_K2D2: begin w_addend = r_f3;   w_sub = 1'b1; end
            P_K1D1: begin w_addend = r_f2;   w_sub = 1'b1; end
            P_K0D0: begin w_addend = r_f1;   w_sub = 1'b1; end
            P_K1F1: begin w_addend = r_dly[1]; w_sub = 1'b0; end
            P_K2F2: begin w_addend = r_dly[2]; w_sub = 1'b0; end
            P_K3F3: begin w_addend = r_dly[3]; w_sub = 1'b0; end
            P_K0G0: begin w_addend = r_dly[0]; w_sub = 1'b0; end
            default: ;
        endcase
    end

    assign w_sum = w_sub ? (SW'(w_addend) - SW'(w_rnd)) : (SW'(w_rnd) + SW'(w_addend));

    assign w_node = (w_sum[SW-1:NB-1] == {(SW - NB + 1){w_sum[SW-1]}}) ? w_sum[NB-1:0]
                  : (w_sum[SW-1] ? NODE_MIN : NODE_MAX);

    assign w_acc_sum = r_acc + AW'(w_rnd);

    // exact ladder sum clipped to the sample range
    assign w_y = (r_acc[AW-1:SAMPLE_BITS-1] == {(AW - SAMPLE_BITS + 1){r_acc[AW-1]}})
               ? r_acc[SAMPLE_BITS-1:0] : (r_acc[AW-1] ? OUT_MIN : OUT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly <= '{default: '0};
        end else begin
            if (w_accept) begin
                r_x <= NB'(signed'(s_axis_tdata[SAMPLE_BITS-1:0]));
            end
            if (r_state == S_RUN) begin
                case (r_wb)
                    P_K3D3: r_f3  <= w_node;
                    P_K2D2: r_f2  <= w_node;
                    P_K1D1: r_f1  <= w_node;
                    P_K0D0: r_g0  <= w_node;
                    P_K1F1: r_g2  <= w_node;
                    P_K2F2: r_g3  <= w_node;
                    P_K3F3: r_g4  <= w_node;
                    P_K0G0: r_g1  <= w_node;
                    P_A0G4: r_acc <= AW'(w_rnd);
                    P_A1G3, P_A2G2, P_A3G1, P_A4G0: r_acc <= w_acc_sum;
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_dly[0] <= r_g0;
                r_dly[1] <= r_g1;
                r_dly[2] <= r_g2;
                r_dly[3] <= r_g3;
            end
        end
    end

    // ---- sequencer and output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= P_LAST;
            r_wb        <= P_LAST;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                        r_step  <= P_K3D3;
                        r_wb    <= P_LAST;
                    end
                end
                S_RUN: begin
                    r_wb <= r_step;
                    if (r_step == P_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= t_step'(4'(r_step) + 4'd1);
                    end
                end
                S_DONE: begin
                    r_wb <= P_LAST;
                    if (w_commit) begin
                        r_out_data <= w_y;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---- checks ----
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN) && (r_step == P_K3D3) && (r_wb == P_LAST))
        else $error("item accepted without starting the multiply sequence");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_step == P_LAST) |=> (r_state == S_DONE))
        else $error("sequence did not finish after the last issue slot");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the completion step");

    a_dly_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_dly[0]) && $stable(r_dly[3]))
        else $error("backward delays changed mid-item");

endmodule

/* rtl/llf_mul.sv */
// Shared multiplier: registered product, then round to nearest (ties up)
// while dropping COEF_BITS-2 fraction bits.
module llf_mul #(
    parameter int COEF_BITS = llf_pkg::COEF_BITS_DEF,
    parameter int NODE_BITS = llf_pkg::SAMPLE_BITS_DEF + llf_pkg::GUARD_BITS
) (
    input  logic                        i_clk,
    input  logic signed [COEF_BITS-1:0] i_coef,
    input  logic signed [NODE_BITS-1:0] i_opnd,
    output logic signed [NODE_BITS+2:0] o_rnd
);

    localparam int PW   = COEF_BITS + NODE_BITS;
    localparam int FRAC = COEF_BITS - 2;

    localparam logic [PW:0] HALF = {{(PW + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};

    logic signed [PW-1:0] r_prod;
    logic        [PW:0]   w_sum;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_opnd;
    end

    // floor((p + half) / 2^FRAC) by slicing off the fraction
    assign w_sum = {r_prod[PW-1], r_prod} + HALF;
    assign o_rnd = w_sum[PW:FRAC];

endmodule
